[design/tmhp_pkg.sv]
// shared types, constants and decode functions of the trace message header parser
package tmhp_pkg;

    // parse phases of the byte walker
    typedef enum logic [4:0] {
        PH_STOR,
        PH_BASE,
        PH_V1_ECU,
        PH_V1_SEID,
        PH_V1_TMSP,
        PH_V1_MSIN,
        PH_V1_NOAR,
        PH_V1_APCT,
        PH_V2_CNTLEN,
        PH_V2_MSIN,
        PH_V2_NOAR,
        PH_V2_TS,
        PH_V2_MID,
        PH_ECULEN,
        PH_ECUSKIP,
        PH_APLEN,
        PH_APSKIP,
        PH_CTLEN,
        PH_CTSKIP,
        PH_V2_SEID,
        PH_FNLEN,
        PH_FNSKIP,
        PH_TAGCNT,
        PH_TAGLEN,
        PH_TAGSKIP,
        PH_PRIV,
        PH_SEGLEN,
        PH_SEGSKIP,
        PH_PAYLOAD,
        PH_HALT
    } t_phase;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_LENGTH   = 3'd1;
    localparam logic [2:0] ST_STOR_VER = 3'd2;
    localparam logic [2:0] ST_VERSION  = 3'd3;
    localparam logic [2:0] ST_RESERVED = 3'd4;

    localparam logic [2:0] VER_1      = 3'd1;
    localparam logic [2:0] VER_2      = 3'd2;
    localparam logic [2:0] MT_CONTROL = 3'd3;

    localparam logic [7:0] STOR_VER_1   = 8'd1;
    localparam logic [7:0] STOR_VER_2   = 8'd2;
    localparam logic [8:0] STOR_V1_SIZE = 9'd16;
    localparam logic [8:0] STOR_V2_BASE = 9'd14;
    localparam logic [16:0] STOR_VER_POS = 17'd3;
    localparam logic [16:0] STOR_ECU_POS = 17'd13;

    localparam logic [16:0] POS_MAX = 17'h1ffff;

    // ns/100000 == (ns >> 5) / 3125, done as a reciprocal multiply
    localparam int          NS_Y_W    = 26;
    localparam int          RECIP_W   = 27;
    localparam int          PROD_W    = NS_Y_W + RECIP_W;
    localparam int          RECIP_SH  = 38;
    localparam logic [RECIP_W-1:0] NS_RECIP = 27'd87960931;
    localparam int          Q_W       = 15;
    localparam logic [13:0] SEC_SCALE = 14'd10000;

    // fields handed from the parser to the output stage
    typedef struct packed {
        logic [2:0]        status;
        logic [2:0]        version;
        logic [7:0]        msg_counter;
        logic [2:0]        msg_type;
        logic [3:0]        msg_subtype;
        logic [1:0]        mode_flags;
        logic [7:0]        arg_count;
        logic              ts_comb;
        logic [39:0]       ts_sec;
        logic [Q_W-1:0]    ts_q;
        logic [31:0]       ts_word;
        logic [31:0]       session_id;
        logic [16:0]       header_size;
        logic [15:0]       payload_size;
        logic [31:0]       id_word;
    } t_raw_result;

    // bytes a phase still takes, zero when the field is absent
    function automatic logic [8:0] phase_size(t_phase ph, logic [11:0] h,
                                              logic [7:0] tags, logic [8:0] skip);
        logic [8:0] sz;
        logic       info;
        info = (h[1:0] == 2'd0) || (h[1:0] == 2'd2);
        sz   = '0;
        unique case (ph)
            PH_BASE:                   sz = 9'd4;
            PH_V1_ECU:                 sz = h[2] ? 9'd4 : 9'd0;
            PH_V1_SEID:                sz = h[3] ? 9'd4 : 9'd0;
            PH_V1_TMSP:                sz = h[4] ? 9'd4 : 9'd0;
            PH_V1_MSIN, PH_V1_NOAR:    sz = h[0] ? 9'd1 : 9'd0;
            PH_V1_APCT:                sz = h[0] ? 9'd8 : 9'd0;
            PH_V2_CNTLEN:              sz = 9'd3;
            PH_V2_MSIN, PH_V2_NOAR:    sz = info ? 9'd1 : 9'd0;
            PH_V2_TS:                  sz = (h[1:0] == 2'd0 || h[1:0] == 2'd1) ? 9'd9 : 9'd0;
            PH_V2_MID:                 sz = (h[1:0] == 2'd1) ? 9'd4 : 9'd0;
            PH_ECULEN:                 sz = h[2] ? 9'd1 : 9'd0;
            PH_APLEN, PH_CTLEN:        sz = h[3] ? 9'd1 : 9'd0;
            PH_V2_SEID:                sz = h[4] ? 9'd4 : 9'd0;
            PH_FNLEN:                  sz = h[8] ? 9'd1 : 9'd0;
            PH_TAGCNT:                 sz = h[9] ? 9'd1 : 9'd0;
            PH_TAGLEN:                 sz = (tags != '0) ? 9'd1 : 9'd0;
            PH_PRIV:                   sz = h[10] ? 9'd1 : 9'd0;
            PH_SEGLEN:                 sz = h[11] ? 9'd1 : 9'd0;
            PH_ECUSKIP, PH_APSKIP, PH_CTSKIP,
            PH_FNSKIP, PH_TAGSKIP, PH_SEGSKIP: sz = skip;
            default:                   sz = '0;
        endcase
        return sz;
    endfunction

    // phase that follows a finished field
    function automatic t_phase phase_succ(t_phase ph);
        t_phase nx;
        if (ph == PH_TAGSKIP) begin
            nx = PH_TAGLEN;
        end else if (ph == PH_SEGSKIP || ph == PH_V1_APCT || ph >= PH_PAYLOAD) begin
            nx = PH_PAYLOAD;
        end else begin
            nx = t_phase'(ph + 5'd1);
        end
        return nx;
    endfunction

    // first present phase at or after start, as a priority pick
    function automatic t_phase settle_target(t_phase start, logic [11:0] h,
                                             logic [7:0] tags, logic [8:0] skip);
        t_phase     eff;
        t_phase     found;
        logic       hit;
        logic [4:0] lim;
        logic [4:0] idx;
        eff = start;
        if (eff == PH_TAGSKIP && skip == '0) begin
            eff = PH_TAGLEN;
        end
        if (eff == PH_TAGLEN && tags == '0) begin
            eff = PH_PRIV;
        end
        lim   = (eff <= PH_V1_APCT) ? 5'(PH_V1_APCT) : 5'(PH_SEGSKIP);
        found = PH_PAYLOAD;
        hit   = 1'b0;
        for (int i = 1; i <= 27; i++) begin
            idx = 5'(i);
            if (!hit && idx >= 5'(eff) && idx <= lim &&
                !(idx == 5'(PH_TAGSKIP) && eff != PH_TAGSKIP)) begin
                if (phase_size(t_phase'(idx), h, tags, skip) != '0) begin
                    found = t_phase'(idx);
                    hit   = 1'b1;
                end
            end
        end
        return found;
    endfunction

endpackage

[design/tmhp_if.sv]
// channel interfaces of the trace message header parser
interface tmhp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;
    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface tmhp_cfg_if;
    logic valid;
    logic ready;
    logic storage_header_present;
    modport source (output valid, output storage_header_present, input ready);
    modport sink   (input valid, input storage_header_present, output ready);
endinterface

interface tmhp_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [2:0]  version;
    logic [7:0]  msg_counter;
    logic [2:0]  msg_type;
    logic [3:0]  msg_subtype;
    logic [1:0]  mode_flags;
    logic [7:0]  arg_count;
    logic [63:0] timestamp;
    logic [31:0] session_id;
    logic [16:0] header_size;
    logic [15:0] payload_size;
    logic [31:0] id_word;
    modport source (output valid, output status, output version, output msg_counter,
                    output msg_type, output msg_subtype, output mode_flags,
                    output arg_count, output timestamp, output session_id,
                    output header_size, output payload_size, output id_word,
                    input ready);
    modport sink   (input valid, input status, input version, input msg_counter,
                    input msg_type, input msg_subtype, input mode_flags,
                    input arg_count, input timestamp, input session_id,
                    input header_size, input payload_size, input id_word,
                    output ready);
endinterface

[design/tmhp_parser.sv]
// per-byte header walker: phase register, field capture and end-of-buffer result
module tmhp_parser import tmhp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic [7:0]  i_data,
    input  logic        i_last,
    input  logic        i_storage_present,
    output t_raw_result o_raw
);

    logic [16:0]        r_pos;
    t_phase             r_phase;
    logic [8:0]         r_ss;
    logic [11:0]        r_htype;
    logic [15:0]        r_len;
    logic [8:0]         r_skip;
    logic [7:0]         r_tags;
    logic [39:0]        r_asm;
    logic [2:0]         r_status;
    logic [2:0]         r_version;
    logic [7:0]         r_counter;
    logic [2:0]         r_type;
    logic [3:0]         r_subtype;
    logic [1:0]         r_mode;
    logic [7:0]         r_args;
    logic               r_ts_flag;
    logic               r_ts_comb;
    logic [39:0]        r_ts_sec;
    logic [31:0]        r_ts_word;
    logic [31:0]        r_sid;
    logic [16:0]        r_hsize;
    logic [15:0]        r_psize;
    logic [31:0]        r_id;
    logic [NS_Y_W-1:0]  r_ns_y;
    logic [PROD_W-1:0]  r_q_prod;

    logic [16:0]        n_pos;
    t_phase             n_phase;
    logic [8:0]         n_ss;
    logic [11:0]        n_htype;
    logic [15:0]        n_len;
    logic [8:0]         n_skip;
    logic [7:0]         n_tags;
    logic [39:0]        n_asm;
    logic [2:0]         n_status;
    logic [2:0]         n_version;
    logic [7:0]         n_counter;
    logic [2:0]         n_type;
    logic [3:0]         n_subtype;
    logic [1:0]         n_mode;
    logic [7:0]         n_args;
    logic               n_ts_flag;
    logic               n_ts_comb;
    logic [39:0]        n_ts_sec;
    logic [31:0]        n_ts_word;
    logic [31:0]        n_sid;
    logic [16:0]        n_hsize;
    logic [15:0]        n_psize;
    logic [31:0]        n_id;
    logic [NS_Y_W-1:0]  n_ns_y;

    logic               first;
    t_phase             c_phase;
    logic [8:0]         c_skip;
    logic               do_settle;
    t_phase             settle_from;
    t_phase             tgt;
    logic               halt;
    logic [2:0]         halt_code;
    logic [16:0]        pay_off;
    logic [16:0]        hdr_len;
    logic [2:0]         st;
    logic [31:0]        id_sel;
    logic [31:0]        pw;

    always_comb begin
        // a new buffer starts from a cleared view of all state but the v2 seconds and ns words
        first   = (r_pos == '0);
        c_phase = first ? (i_storage_present ? PH_STOR : PH_BASE) : r_phase;
        c_skip  = first ? (i_storage_present ? 9'd0 : 9'd4) : r_skip;

        n_phase   = c_phase;
        n_skip    = c_skip;
        n_ss      = first ? '0 : r_ss;
        n_htype   = first ? '0 : r_htype;
        n_len     = first ? '0 : r_len;
        n_tags    = first ? '0 : r_tags;
        n_asm     = first ? '0 : r_asm;
        n_status  = first ? '0 : r_status;
        n_version = first ? '0 : r_version;
        n_counter = first ? '0 : r_counter;
        n_type    = first ? '0 : r_type;
        n_subtype = first ? '0 : r_subtype;
        n_mode    = first ? '0 : r_mode;
        n_args    = first ? '0 : r_args;
        n_ts_flag = first ? 1'b0 : r_ts_flag;
        n_ts_comb = first ? 1'b0 : r_ts_comb;
        n_ts_sec  = r_ts_sec;
        n_ts_word = first ? '0 : r_ts_word;
        n_sid     = first ? '0 : r_sid;
        n_hsize   = first ? '0 : r_hsize;
        n_psize   = first ? '0 : r_psize;
        n_id      = first ? '0 : r_id;
        n_ns_y    = r_ns_y;

        n_pos       = (r_pos < POS_MAX) ? r_pos + 17'd1 : r_pos;
        do_settle   = 1'b0;
        settle_from = PH_BASE;
        halt        = 1'b0;
        halt_code   = ST_OK;
        pay_off     = r_pos - n_hsize;
        tgt         = PH_PAYLOAD;
        hdr_len     = '0;

        unique case (c_phase)
            PH_STOR: begin
                if (r_pos == STOR_VER_POS) begin
                    if (i_data == STOR_VER_1) begin
                        n_ss = STOR_V1_SIZE;
                    end else if (i_data == STOR_VER_2) begin
                        n_ss = STOR_V2_BASE;
                    end else begin
                        halt      = 1'b1;
                        halt_code = ST_STOR_VER;
                    end
                end
                if (!halt && r_pos == STOR_ECU_POS && n_ss == STOR_V2_BASE) begin
                    n_ss = STOR_V2_BASE + 9'(i_data);
                end
                if (!halt && n_ss != '0 && n_pos == 17'(n_ss)) begin
                    do_settle   = 1'b1;
                    settle_from = PH_BASE;
                end
            end
            PH_PAYLOAD: begin
                // first four payload bytes, little-endian
                if (r_pos >= n_hsize && pay_off < 17'd4) begin
                    case (pay_off[1:0])
                        2'd0:    n_asm[7:0]   = n_asm[7:0]   | i_data;
                        2'd1:    n_asm[15:8]  = n_asm[15:8]  | i_data;
                        2'd2:    n_asm[23:16] = n_asm[23:16] | i_data;
                        default: n_asm[31:24] = n_asm[31:24] | i_data;
                    endcase
                end
            end
            PH_HALT: begin
            end
            default: begin
                n_asm = {n_asm[31:0], i_data};
                if (c_skip != '0) begin
                    n_skip = c_skip - 9'd1;
                end
                // v2 timestamp: nanosecond word after four bytes, seconds after five more
                if (c_phase == PH_V2_TS && n_skip == 9'd5) begin
                    n_ts_flag = n_asm[31];
                    n_ns_y    = n_asm[30:5];
                    n_asm     = '0;
                end
                if (n_skip == '0) begin
                    do_settle   = 1'b1;
                    settle_from = phase_succ(c_phase);
                    case (c_phase)
                        PH_BASE: begin
                            n_htype   = {n_asm[19:16], n_asm[31:24]};
                            n_version = n_asm[31:29];
                            if (n_asm[31:29] == VER_1) begin
                                n_counter   = n_asm[23:16];
                                n_len       = n_asm[15:0];
                                n_mode      = n_asm[25] ? 2'd2 : 2'd0;
                                settle_from = PH_V1_ECU;
                            end else if (n_asm[31:29] == VER_2) begin
                                settle_from = PH_V2_CNTLEN;
                            end else begin
                                halt      = 1'b1;
                                halt_code = ST_VERSION;
                            end
                        end
                        PH_V2_CNTLEN: begin
                            n_counter = n_asm[23:16];
                            n_len     = n_asm[15:0];
                            if (n_htype[1:0] == 2'd3) begin
                                halt      = 1'b1;
                                halt_code = ST_RESERVED;
                            end
                            if (n_htype[1:0] == 2'd0) begin
                                n_mode = 2'd1;
                            end
                        end
                        PH_V1_SEID, PH_V2_SEID: n_sid = n_asm[31:0];
                        PH_V1_TMSP:             n_ts_word = n_asm[31:0];
                        PH_V1_MSIN: begin
                            n_type    = i_data[3:1];
                            n_subtype = i_data[7:4];
                            n_mode[0] = n_mode[0] | i_data[0];
                        end
                        PH_V1_NOAR: n_args = n_mode[0] ? i_data : 8'd0;
                        PH_V2_MSIN: begin
                            if (i_data[3:1] > MT_CONTROL) begin
                                halt      = 1'b1;
                                halt_code = ST_RESERVED;
                            end else begin
                                n_type    = i_data[3:1];
                                n_subtype = i_data[7:4];
                            end
                        end
                        PH_V2_NOAR: n_args = i_data;
                        PH_V2_TS: begin
                            n_ts_comb = n_ts_flag;
                            n_ts_sec  = n_asm;
                        end
                        PH_V2_MID: n_id = n_asm[31:0];
                        PH_ECULEN, PH_APLEN, PH_CTLEN, PH_FNLEN, PH_SEGLEN:
                            n_skip = 9'(i_data);
                        PH_TAGCNT: n_tags = i_data;
                        PH_TAGLEN: begin
                            n_tags = n_tags - 8'd1;
                            n_skip = 9'(i_data);
                        end
                        default: begin
                        end
                    endcase
                end
            end
        endcase

        if (halt) begin
            n_phase  = PH_HALT;
            n_status = halt_code;
        end else if (do_settle) begin
            tgt     = settle_target(settle_from, n_htype, n_tags, n_skip);
            n_phase = tgt;
            n_asm   = '0;
            if (tgt == PH_PAYLOAD) begin
                n_hsize = n_pos;
                hdr_len = (n_pos >= 17'(n_ss)) ? n_pos - 17'(n_ss) : 17'd0;
                n_psize = (17'(n_len) >= hdr_len) ? 16'(17'(n_len) - hdr_len) : 16'd0;
            end else begin
                n_skip = phase_size(tgt, n_htype, n_tags, n_skip);
            end
        end

        // end-of-buffer verdict
        if (n_phase == PH_HALT) begin
            st = n_status;
        end else if (n_phase != PH_PAYLOAD) begin
            st = ST_LENGTH;
        end else if (n_version == VER_1 &&
                     18'(n_pos) < 18'(n_hsize) + 18'(n_psize)) begin
            st = ST_LENGTH;
        end else begin
            st = ST_OK;
        end

        pw     = n_asm[31:0];
        id_sel = n_id;
        if (n_version == VER_1) begin
            if (n_psize >= 16'd4 && (!n_mode[0] || n_type == MT_CONTROL)) begin
                id_sel = n_mode[1] ? {pw[7:0], pw[15:8], pw[23:16], pw[31:24]} : pw;
            end
        end else if (n_htype[1:0] != 2'd1 && n_type == MT_CONTROL &&
                     n_psize >= 16'd4 && (n_pos - n_hsize) >= 17'd4) begin
            id_sel = pw;
        end

        o_raw = '0;
        o_raw.status  = st;
        o_raw.version = n_version;
        if (st == ST_OK) begin
            o_raw.msg_counter  = n_counter;
            o_raw.msg_type     = n_type;
            o_raw.msg_subtype  = n_subtype;
            o_raw.mode_flags   = n_mode;
            o_raw.arg_count    = n_args;
            o_raw.ts_comb      = n_ts_comb;
            o_raw.ts_sec       = n_ts_sec;
            o_raw.ts_q         = r_q_prod[PROD_W-1:RECIP_SH];
            o_raw.ts_word      = n_ts_word;
            o_raw.session_id   = n_sid;
            o_raw.header_size  = n_hsize;
            o_raw.payload_size = n_psize;
            o_raw.id_word      = id_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= PH_STOR;
        end else if (i_take) begin
            r_pos   <= i_last ? 17'd0 : n_pos;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_ss      <= n_ss;
            r_htype   <= n_htype;
            r_len     <= n_len;
            r_skip    <= n_skip;
            r_tags    <= n_tags;
            r_asm     <= n_asm;
            r_status  <= n_status;
            r_version <= n_version;
            r_counter <= n_counter;
            r_type    <= n_type;
            r_subtype <= n_subtype;
            r_mode    <= n_mode;
            r_args    <= n_args;
            r_ts_flag <= n_ts_flag;
            r_ts_comb <= n_ts_comb;
            r_ts_sec  <= n_ts_sec;
            r_ts_word <= n_ts_word;
            r_sid     <= n_sid;
            r_hsize   <= n_hsize;
            r_psize   <= n_psize;
            r_id      <= n_id;
            r_ns_y    <= n_ns_y;
        end
        // quotient settles long before the seconds bytes are in
        r_q_prod <= PROD_W'(r_ns_y) * PROD_W'(NS_RECIP);
    end

`ifndef SYNTHESIS
    a_halt_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos != '0 && r_phase == PH_HALT) |-> (r_status != ST_OK))
        else $error("halted parse without an error code");
    a_field_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos != '0 && r_phase != PH_STOR && r_phase != PH_PAYLOAD &&
         r_phase != PH_HALT) |-> (r_skip != '0))
        else $error("header field phase with nothing left to read");
    a_hsize_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos != '0 && r_phase == PH_PAYLOAD) |-> (r_hsize <= r_pos))
        else $error("header size beyond bytes seen");
`endif

endmodule

[design/tmhp_ts_out.sv]
// output register with the v2 timestamp combine
module tmhp_ts_out import tmhp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  t_raw_result   i_raw,
    output logic          o_take,
    tmhp_result_if.source o_result_ch
);

    logic              r_valid;
    t_raw_result       r_raw;
    logic [63:0]       r_ts;
    logic [53:0]       sec_scaled;
    logic [63:0]       n_ts;

    assign o_take = !r_valid || o_result_ch.ready;

    always_comb begin
        sec_scaled = 54'(i_raw.ts_sec) * 54'(SEC_SCALE);
        n_ts = i_raw.ts_comb ? 64'(sec_scaled) + 64'(i_raw.ts_q)
                             : {32'd0, i_raw.ts_word};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_raw <= i_raw;
            r_ts  <= n_ts;
        end
    end

    assign o_result_ch.valid        = r_valid;
    assign o_result_ch.status       = r_raw.status;
    assign o_result_ch.version      = r_raw.version;
    assign o_result_ch.msg_counter  = r_raw.msg_counter;
    assign o_result_ch.msg_type     = r_raw.msg_type;
    assign o_result_ch.msg_subtype  = r_raw.msg_subtype;
    assign o_result_ch.mode_flags   = r_raw.mode_flags;
    assign o_result_ch.arg_count    = r_raw.arg_count;
    assign o_result_ch.timestamp    = r_ts;
    assign o_result_ch.session_id   = r_raw.session_id;
    assign o_result_ch.header_size  = r_raw.header_size;
    assign o_result_ch.payload_size = r_raw.payload_size;
    assign o_result_ch.id_word      = r_raw.id_word;

endmodule

[design/trace_message_header_parser.sv]
// top level of the trace message header parser
//
//  channel      dir  payload                                   moves on
//  i_cfg_ch     in   storage_header_present                    valid & ready
//  i_byte_ch    in   data_byte, last                           valid & ready
//  o_result_ch  out  status .. id_word (one per buffer)        valid & ready
//
//  one byte request per cycle unless stalled; the per-byte decode sits
//  between the parser state registers and a result hold register
//  a buffer's result passes the hold register, then the output register
//  where the v2 timestamp is scaled
//  reset (synchronous, active low) empties both result stages and points the
//  parser at a fresh buffer; the storage header flag resets to 0
//  bytes stall only while both result stages are full and the output waits
module trace_message_header_parser import tmhp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tmhp_cfg_if.sink      i_cfg_ch,
    tmhp_byte_if.sink     i_byte_ch,
    tmhp_result_if.source o_result_ch
);

    logic        r_storage_present;
    logic        r_a_valid;
    t_raw_result r_a_raw;
    t_raw_result raw;
    logic        a_take;
    logic        byte_take;

    // config is always taken
    assign i_cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_storage_present <= 1'b0;
        end else if (i_cfg_ch.valid) begin
            r_storage_present <= i_cfg_ch.storage_header_present;
        end
    end

    // bytes flow while the hold stage is empty or draining this cycle
    assign i_byte_ch.ready = !r_a_valid || a_take;
    assign byte_take       = i_byte_ch.valid && i_byte_ch.ready;

    tmhp_parser u_parser (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_take            (byte_take),
        .i_data            (i_byte_ch.data_byte),
        .i_last            (i_byte_ch.last),
        .i_storage_present (r_storage_present),
        .o_raw             (raw)
    );

    // result hold stage, loaded on the last byte of a buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (byte_take && i_byte_ch.last) begin
            r_a_valid <= 1'b1;
        end else if (a_take) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (byte_take && i_byte_ch.last) begin
            r_a_raw <= raw;
        end
    end

    // timestamp scaling and output register
    tmhp_ts_out u_ts_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_a_valid),
        .i_raw       (r_a_raw),
        .o_take      (a_take),
        .o_result_ch (o_result_ch)
    );

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_byte_ch.ready |-> (r_a_valid && o_result_ch.valid))
        else $error("byte request stalled with room in the result stages");
    a_error_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_ch.valid && o_result_ch.status != ST_OK) |->
        (o_result_ch.timestamp == '0 && o_result_ch.payload_size == '0 &&
         o_result_ch.id_word == '0 && o_result_ch.header_size == '0))
        else $error("error result carries field data");
    a_ok_version: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_ch.valid && o_result_ch.status == ST_OK) |->
        (o_result_ch.version == VER_1 || o_result_ch.version == VER_2))
        else $error("ok result with unsupported version");
`endif

endmodule
